// ----- hdl/nla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_pkg
// Shared widths, defaults and input mode codes for the nearest landmark
// association block.
// ----------------------------------------------------------------------------
package nla_pkg;

    // Default table depth.
    localparam int MAX_LANDMARKS_DEF = 64;

    // Field widths.
    localparam int COORD_W = 24;
    localparam int IDENT_W = 16;
    localparam int DIST_W  = 52;
    localparam int MODE_W  = 2;

    // A coordinate difference needs one more bit than a coordinate.
    localparam int DIFF_W = COORD_W + 1;
    // Its magnitude stays below 2^24, so its square fits in 48 bits.
    localparam int SQ_W   = 2 * COORD_W;
    // Sum of two squares.
    localparam int SUM_W  = SQ_W + 1;

    // Input mode codes; the fourth code means nothing.
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // One table entry as it is stored in the memory.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [IDENT_W-1:0] ident;
    } entry_t;

endpackage

// ----- hdl/nearest_landmark_association.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_landmark_association
// Holds a table of landmarks in one memory and answers nearest-neighbor
// queries by squared Euclidean distance.
//
//   Channel   Direction  Handshake           Words
//   s_*       in         s_valid / s_ready   mode, point_x, point_y, ident
//   m_*       out        m_valid / m_ready   nearest_ident, found, dist, full
//
// A clear or an append is taken in the idle state. A query reads one entry
// per cycle from the single read port of the table memory, then drains the
// distance pipeline before its word reaches the output register; an empty
// table skips the scan. A dropped append sends its word through the result
// state. Reset empties the table through the entry count; the memory itself
// is not cleared, so no clearing pass runs. A stalled output holds its word
// while the block takes further clears and appends; a second result waits.
// ----------------------------------------------------------------------------
module nearest_landmark_association
    import nla_pkg::*;
#(
    parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [MODE_W-1:0]         s_mode,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic [IDENT_W-1:0]        s_landmark_ident,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDENT_W-1:0]        m_nearest_ident,
    output logic                      m_found,
    output logic [DIST_W-1:0]         m_min_dist_sq,
    output logic                      m_table_full
);

    localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CW = $clog2(MAX_LANDMARKS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LANDMARKS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic                      full_flag_reg;
    logic                      have_reg;
    logic [SUM_W-1:0]          best_reg;
    logic [IDENT_W-1:0]        best_ident_reg;
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;

    logic                      m_valid_reg;
    logic [IDENT_W-1:0]        m_ident_reg;
    logic                      m_found_reg;
    logic [DIST_W-1:0]         m_dist_reg;
    logic                      m_full_reg;

    // Table memory and its read pipeline.
    entry_t                    mem [MAX_LANDMARKS];
    entry_t                    rd_data_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [IDENT_W-1:0]        id2_reg, id3_reg, id4_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y;

    logic accept_in;
    logic wr_en;
    logic rd_en;
    logic pipe_busy;
    logic out_free;
    logic take_best;
    entry_t wr_word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign wr_en     = accept_in && (s_mode == MODE_APPEND) && (count_reg != COUNT_MAX);
    assign rd_en     = (state_reg == ST_SCAN);
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign take_best = v4_reg && (!have_reg || (sum_reg < best_reg));

    assign wr_word.x     = s_point_x;
    assign wr_word.y     = s_point_y;
    assign wr_word.ident = s_landmark_ident;

    // Writes happen only in the idle state and reads only during a scan, so
    // the two never touch the same entry in overlapping cycles.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= wr_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // Distance pipeline: difference, squares, sum.
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        dx_reg  <= DIFF_W'(qx_reg) - DIFF_W'(rd_data_reg.x);
        dy_reg  <= DIFF_W'(qy_reg) - DIFF_W'(rd_data_reg.y);
        id2_reg <= rd_data_reg.ident;
        sqx_reg <= prod_x[SQ_W-1:0];
        sqy_reg <= prod_y[SQ_W-1:0];
        id3_reg <= id2_reg;
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        id4_reg <= id3_reg;
    end

    // Valid bits that follow each read down the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (s_mode == MODE_QUERY) begin
                        state_next = (count_reg == '0) ? ST_RESULT : ST_SCAN;
                    end else if (s_mode == MODE_APPEND && count_reg == COUNT_MAX) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_reg == count_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer, table count, running minimum and output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            have_reg      <= 1'b0;
            full_flag_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // A taken word leaves the output register unless a new one loads.
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        qx_reg        <= s_point_x;
                        qy_reg        <= s_point_y;
                        idx_reg       <= '0;
                        have_reg      <= 1'b0;
                        full_flag_reg <= (s_mode == MODE_APPEND);
                        if (s_mode == MODE_CLEAR) begin
                            count_reg <= '0;
                        end else if (wr_en) begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_DRAIN: begin
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_full_reg  <= full_flag_reg;
                        m_found_reg <= have_reg;
                        m_ident_reg <= have_reg ? best_ident_reg : '0;
                        m_dist_reg  <= have_reg ? DIST_W'(best_reg) : '0;
                    end
                end
                default: begin
                end
            endcase

            // The first entry seen always wins; later ones only when closer.
            if (take_best) begin
                have_reg       <= 1'b1;
                best_reg       <= sum_reg;
                best_ident_reg <= id4_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_ident = m_ident_reg;
    assign m_found         = m_found_reg;
    assign m_min_dist_sq   = m_dist_reg;
    assign m_table_full    = m_full_reg;

    // The table count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("entry count exceeds table depth");

    // Reads only reach entries that were loaded.
    a_read_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (idx_reg < count_reg))
        else $error("scan reads beyond loaded entries");

    // No table write while a scan is still in flight.
    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !pipe_busy)
        else $error("table write overlaps a scan");

    // A dropped append reports nothing found.
    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> (!m_found && m_nearest_ident == '0
                                       && m_min_dist_sq == '0))
        else $error("table full word carries a match");

    // A query word is loaded only after the pipeline has drained.
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> !pipe_busy)
        else $error("result taken before scan finished");

endmodule
